### design/lsmu_pkg.sv
// ----------------------------------------------------------------------------
// lsmu_pkg
// Types, codes and a helper function shared by the load/store memory unit.
// ----------------------------------------------------------------------------
package lsmu_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 32;
   localparam int LIMIT_W    = 14;
   localparam int WORD_IDX_W = ADDR_W - 2;
   localparam int CSR_IDX_W  = 1;

   // Access operations.
   localparam logic [1:0] OP_FETCH = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_STORE = 2'd2;

   // Width codes.
   localparam logic [2:0] WC_BYTE  = 3'b000;
   localparam logic [2:0] WC_HALF  = 3'b001;
   localparam logic [2:0] WC_WORD  = 3'b010;
   localparam logic [2:0] WC_UBYTE = 3'b011;
   localparam logic [2:0] WC_UHALF = 3'b100;

   // Result status codes.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_UNALIGNED     = 3'd1;
   localparam logic [2:0] ST_FETCH_OUTSIDE = 3'd2;
   localparam logic [2:0] ST_PROTECTED     = 3'd3;
   localparam logic [2:0] ST_BAD           = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_LIMIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RODATA_LIMIT = 1'b1;

   // What the back end does with a queued command.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // Byte lane masks used for load extraction.
   localparam logic [DATA_W-1:0] MASK_BYTE0 = 32'h0000_00FF;
   localparam logic [DATA_W-1:0] MASK_HALF0 = 32'h0000_FFFF;

   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            status;
      logic [WORD_IDX_W-1:0] word_idx;
      logic [3:0]            byte_en;
      logic [DATA_W-1:0]     wdata;
      logic [1:0]            lane;
      logic [2:0]            width_code;
   } lsmu_cmd_type;

   // Bytes moved by a width code; zero for a code with no meaning.
   function automatic logic [2:0] access_size(input logic [2:0] code);
      logic [2:0] size;
      case (code)
         WC_BYTE, WC_UBYTE: size = 3'd1;
         WC_HALF, WC_UHALF: size = 3'd2;
         WC_WORD:           size = 3'd4;
         default:           size = 3'd0;
      endcase
      return size;
   endfunction

endpackage

### design/lsmu_if.sv
// ----------------------------------------------------------------------------
// lsmu channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsmu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [2:0]  width_code;
   logic [15:0] address;
   logic [31:0] store_data;

   modport source (output valid, op, width_code, address, store_data, input ready);
   modport sink   (input valid, op, width_code, address, store_data, output ready);
endinterface

interface lsmu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [2:0]  status;

   modport source (output valid, read_data, status, input ready);
   modport sink   (input valid, read_data, status, output ready);
endinterface

interface lsmu_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [13:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/lsmu_front.sv
// ----------------------------------------------------------------------------
// lsmu_front
// Holds the segment limits and classifies each request into a command.
// ----------------------------------------------------------------------------
module lsmu_front #(
   parameter int MEM_BYTES = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   lsmu_req_if.sink              req_chan,
   lsmu_csr_if.sink              csr_chan,
   input  logic                  queue_ready,
   output logic                  push,
   output lsmu_pkg::lsmu_cmd_type cmd
);
   import lsmu_pkg::*;

   localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_BYTES);

   logic [LIMIT_W-1:0] text_limit_ff, text_limit_in;
   logic [LIMIT_W-1:0] rodata_limit_ff, rodata_limit_in;

   logic [2:0]      size;
   logic [2:0]      check_size;
   logic [1:0]      align_mask;
   logic [ADDR_W:0] end_addr;
   logic [2:0]      place_status;
   logic [2:0]      status;
   logic [3:0]      lane_mask;
   logic            above_text;
   logic            above_rodata;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = queue_ready;
   assign push           = req_chan.valid && queue_ready;

   always_comb begin
      text_limit_in   = text_limit_ff;
      rodata_limit_in = rodata_limit_ff;
      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_TEXT_LIMIT) begin
            text_limit_in = csr_chan.data;
         end else begin
            rodata_limit_in = csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_limit_ff   <= '0;
         rodata_limit_ff <= '0;
      end else begin
         text_limit_ff   <= text_limit_in;
         rodata_limit_ff <= rodata_limit_in;
      end
   end

   always_comb begin
      size         = access_size(req_chan.width_code);
      check_size   = (req_chan.op == OP_FETCH) ? 3'd4 : size;
      align_mask   = (check_size == 3'd4) ? 2'b11 : ((check_size == 3'd2) ? 2'b01 : 2'b00);
      end_addr     = {1'b0, req_chan.address} + {{(ADDR_W-2){1'b0}}, check_size};
      above_text   = req_chan.address > {2'b00, text_limit_ff};
      above_rodata = req_chan.address > {2'b00, rodata_limit_ff};

      if ((req_chan.address[1:0] & align_mask) != 2'b00) begin
         place_status = ST_UNALIGNED;
      end else if (end_addr > MEM_LIMIT) begin
         place_status = ST_BAD;
      end else begin
         place_status = ST_OK;
      end

      case (req_chan.op)
         OP_FETCH: status = above_text ? ST_FETCH_OUTSIDE : place_status;
         OP_LOAD:  status = (size == 3'd0) ? ST_BAD : place_status;
         OP_STORE: begin
            if (!above_text || !above_rodata) begin
               status = ST_PROTECTED;
            end else if (req_chan.width_code > WC_WORD) begin
               status = ST_BAD;
            end else begin
               status = place_status;
            end
         end
         default:  status = ST_BAD;
      endcase

      case (size)
         3'd1:    lane_mask = 4'b0001;
         3'd2:    lane_mask = 4'b0011;
         default: lane_mask = 4'b1111;
      endcase

      cmd.status     = status;
      cmd.word_idx   = req_chan.address[ADDR_W-1:2];
      cmd.lane       = req_chan.address[1:0];
      cmd.byte_en    = lane_mask << req_chan.address[1:0];
      cmd.wdata      = req_chan.store_data << {req_chan.address[1:0], 3'b000};
      cmd.width_code = (req_chan.op == OP_FETCH) ? WC_WORD : req_chan.width_code;
      if (status != ST_OK) begin
         cmd.kind = KIND_NONE;
      end else if (req_chan.op == OP_STORE) begin
         cmd.kind = KIND_WRITE;
      end else begin
         cmd.kind = KIND_READ;
      end
   end

endmodule

### design/lsmu_queue.sv
// ----------------------------------------------------------------------------
// lsmu_queue
// Two-entry command queue that decouples classification from execution.
// ----------------------------------------------------------------------------
module lsmu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lsmu_pkg::lsmu_cmd_type push_cmd,
   output logic                   ready,
   input  logic                   pop,
   output logic                   head_valid,
   output lsmu_pkg::lsmu_cmd_type head_cmd
);
   import lsmu_pkg::*;

   lsmu_cmd_type entry_ff [2];
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign ready      = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/lsmu_back.sv
// ----------------------------------------------------------------------------
// lsmu_back
// Executes queued commands against the word memory and drives responses.
// ----------------------------------------------------------------------------
module lsmu_back #(
   parameter int MEM_BYTES = 16384
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  lsmu_pkg::lsmu_cmd_type cmd,
   output logic                   pop,
   lsmu_rsp_if.source             rsp_chan
);
   import lsmu_pkg::*;

   localparam int DEPTH = (MEM_BYTES + 3) / 4;
   localparam int IDX_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [2:0]        status_ff;
   logic [1:0]        lane_ff;
   logic [2:0]        code_ff;
   logic [DATA_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  idx;
   logic [DATA_W-1:0] raw;
   logic [DATA_W-1:0] value;

   assign idx      = cmd.word_idx[IDX_W-1:0];
   assign pop      = cmd_valid && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= cmd.kind;
         status_ff <= cmd.status;
         lane_ff   <= cmd.lane;
         code_ff   <= cmd.width_code;
      end
   end

   // Byte-enabled write port and registered read port.
   always_ff @(posedge clock) begin
      if (pop && cmd.kind == KIND_WRITE) begin
         for (int b = 0; b < 4; b++) begin
            if (cmd.byte_en[b]) begin
               mem[idx][8*b +: 8] <= cmd.wdata[8*b +: 8];
            end
         end
      end
      if (pop && cmd.kind == KIND_READ) begin
         rdata_ff <= mem[idx];
      end
   end

   always_comb begin
      raw = rdata_ff >> {lane_ff, 3'b000};
      case (code_ff)
         WC_BYTE:  value = {{24{raw[7]}}, raw[7:0]};
         WC_HALF:  value = {{16{raw[15]}}, raw[15:0]};
         WC_WORD:  value = raw;
         WC_UBYTE: value = raw & MASK_BYTE0;
         default:  value = raw & MASK_HALF0;
      endcase
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.read_data = (kind_ff == KIND_READ) ? value : '0;

endmodule

### design/load_store_memory_unit.sv
// ----------------------------------------------------------------------------
// load_store_memory_unit
// Little-endian byte-addressed memory serving fetches, loads and stores.
// ----------------------------------------------------------------------------
// A request passes through the command queue and the response register.
// One transaction is taken per cycle while the response side is not stalled,
// set by the single memory port, used for a read or a write in each cycle.
// Reset clears the segment limits, the command queue and the response stage;
// memory contents are not cleared and are undefined until written.
module load_store_memory_unit #(
   parameter int MEM_BYTES = 16384
) (
   input logic        clock,
   input logic        reset,
   lsmu_req_if.sink   req_chan,
   lsmu_rsp_if.source rsp_chan,
   lsmu_csr_if.sink   csr_chan
);
   import lsmu_pkg::*;

   // The front end checks alignment, range and segment protection as the
   // request transaction is accepted, and turns the access into a command
   // carrying the word index, byte enables and lane-aligned store data.
   logic         push;
   logic         queue_ready;
   logic         pop;
   logic         head_valid;
   lsmu_cmd_type front_cmd;
   lsmu_cmd_type head_cmd;

   lsmu_front #(
      .MEM_BYTES (MEM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .queue_ready (queue_ready),
      .push        (push),
      .cmd         (front_cmd)
   );

   // The queue lets new transactions enter while the response side is
   // stalled, and lets the back end drain while no requests arrive.
   lsmu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .ready      (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The back end performs the memory access in order. Refused accesses
   // touch nothing and return zero data with their status.
   lsmu_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the load/store memory unit. Fetches, loads and
// stores are pushed through the request channel under five pairs of segment
// limits. Each response is checked against a shadow memory kept in the bench.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import lsmu_pkg::*;

   localparam int MEM_BYTES      = 16384;
   localparam int WORDS          = MEM_BYTES / 4;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [LIMIT_W-1:0] LIMIT_MIN = '0;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   // Codes that the package leaves unnamed, because the unit only rejects them.
   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic [2:0] WC_UNUSED      = 3'd5;
   localparam logic [2:0] WC_UNUSED_LAST = 3'd7;

   typedef struct packed {
      logic [1:0]        op;
      logic [2:0]        width_code;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] store_data;
   } access_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [2:0]        status;
   } reply_type;

   logic clock;
   logic reset;

   lsmu_req_if req_chan ();
   lsmu_rsp_if rsp_chan ();
   lsmu_csr_if csr_chan ();

   load_store_memory_unit #(
      .MEM_BYTES (MEM_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Transactions waiting to be driven, and the replies predicted for the
   // requests that the unit has already taken, oldest first.
   access_type access_backlog[$];
   reply_type  awaited_replies[$];

   // Shadow state of the unit, updated only as transactions are accepted.
   logic [DATA_W-1:0]  model_words [0:WORDS-1];
   logic [LIMIT_W-1:0] model_text;
   logic [LIMIT_W-1:0] model_rodata;

   // State seen by the stimulus generator as it plans ahead. A byte is marked
   // once a successful store covers it, so that no successful read ever
   // touches a location whose contents are still undefined.
   bit                 byte_written [0:MEM_BYTES-1];
   int unsigned        known_words[$];
   logic [LIMIT_W-1:0] plan_text;
   logic [LIMIT_W-1:0] plan_rodata;

   bit          calm;          // when set, neither side idles
   logic        req_taken;     // request accepted at the last rising edge
   int          failures;
   int          stall_cycles;
   int          settings_run;
   int unsigned op_count     [0:3];
   int unsigned status_count [0:7];

   // -------------------------------------------------------------------------
   // Clock and time-zero values
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Access rules
   // -------------------------------------------------------------------------

   // Bytes touched by an access. A fetch is always a whole word; a width code
   // with no meaning moves nothing.
   function automatic int unsigned bytes_moved(access_type a);
      if (a.op == OP_FETCH) return 4;
      case (a.width_code)
         WC_BYTE, WC_UBYTE: return 1;
         WC_HALF, WC_UHALF: return 2;
         WC_WORD:           return 4;
         default:           return 0;
      endcase
   endfunction

   // Alignment first, then whether the last byte still lies inside memory.
   function automatic logic [2:0] place_verdict(int unsigned addr, int unsigned span);
      if (addr % span != 0) return ST_UNALIGNED;
      if (addr + span > MEM_BYTES) return ST_BAD;
      return ST_OK;
   endfunction

   // Status of an access under a given pair of segment limits. The order of
   // the checks matters: a store into a protected segment is reported as such
   // even when its width code or alignment is also wrong.
   function automatic logic [2:0] judge_access(access_type a, logic [LIMIT_W-1:0] text_lim,
                                               logic [LIMIT_W-1:0] ro_lim);
      int unsigned span;
      logic [2:0]  verdict;
      span = bytes_moved(a);
      case (a.op)
         OP_FETCH: begin
            if (a.address > text_lim) verdict = ST_FETCH_OUTSIDE;
            else verdict = place_verdict(32'(a.address), span);
         end
         OP_LOAD: begin
            if (span == 0) verdict = ST_BAD;
            else verdict = place_verdict(32'(a.address), span);
         end
         OP_STORE: begin
            if (a.address <= text_lim || a.address <= ro_lim) verdict = ST_PROTECTED;
            else if (a.width_code > WC_WORD) verdict = ST_BAD;
            else verdict = place_verdict(32'(a.address), span);
         end
         default: begin
            verdict = ST_BAD;
         end
      endcase
      return verdict;
   endfunction

   // Reply to one accepted request; a successful store also updates the
   // shadow memory. Refused accesses read zero and change nothing.
   function automatic reply_type memory_reply(access_type a);
      reply_type         r;
      logic [DATA_W-1:0] lanes;
      logic [DATA_W-1:0] mask;
      int unsigned       ix;
      int unsigned       sh;
      r.status    = judge_access(a, model_text, model_rodata);
      r.read_data = '0;
      ix = 32'(a.address >> 2);
      sh = 8 * a.address[1:0];
      if (r.status == ST_OK) begin
         lanes = model_words[ix] >> sh;
         case (a.op)
            OP_FETCH: begin
               r.read_data = model_words[ix];
            end
            OP_LOAD: begin
               case (a.width_code)
                  WC_BYTE:  r.read_data = {{24{lanes[7]}}, lanes[7:0]};
                  WC_HALF:  r.read_data = {{16{lanes[15]}}, lanes[15:0]};
                  WC_WORD:  r.read_data = lanes;
                  WC_UBYTE: r.read_data = {24'h0, lanes[7:0]};
                  default:  r.read_data = {16'h0, lanes[15:0]};
               endcase
            end
            default: begin
               case (a.width_code)
                  WC_BYTE: mask = 32'h0000_00FF;
                  WC_HALF: mask = 32'h0000_FFFF;
                  default: mask = 32'hFFFF_FFFF;
               endcase
               model_words[ix] = (model_words[ix] & ~(mask << sh))
                               | ((a.store_data & mask) << sh);
            end
         endcase
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus planning
   // -------------------------------------------------------------------------
   function automatic access_type acc(logic [1:0] op, logic [2:0] wc, int unsigned addr,
                                      logic [DATA_W-1:0] data);
      access_type a;
      a.op         = op;
      a.width_code = wc;
      a.address    = ADDR_W'(addr);
      a.store_data = data;
      return a;
   endfunction

   // True when a read would succeed but would touch a byte never written.
   function automatic bit touches_unknown(access_type a);
      int unsigned n;
      bit          miss;
      miss = 1'b0;
      if (a.op != OP_STORE && judge_access(a, plan_text, plan_rodata) == ST_OK) begin
         for (n = 0; n < bytes_moved(a); n++) begin
            if (!byte_written[a.address + n]) miss = 1'b1;
         end
      end
      return miss;
   endfunction

   task automatic queue_access(input access_type a);
      int unsigned n;
      access_backlog.push_back(a);
      if (a.op == OP_STORE && judge_access(a, plan_text, plan_rodata) == ST_OK) begin
         for (n = 0; n < bytes_moved(a); n++) byte_written[a.address + n] = 1'b1;
         known_words.push_back(32'(a.address >> 2));
      end
   endtask

   // Mostly accesses around words that already hold data, so that loads and
   // fetches succeed often; the rest spread over the low region, the top of
   // memory and the whole address space, with some bad codes mixed in.
   function automatic access_type random_access();
      access_type  a;
      int unsigned roll;
      int unsigned base;
      int unsigned span;
      roll = $urandom_range(0, 99);
      if (roll < 35)      a.op = OP_STORE;
      else if (roll < 70) a.op = OP_LOAD;
      else if (roll < 96) a.op = OP_FETCH;
      else                a.op = OP_UNUSED;
      if (a.op == OP_STORE) begin
         if ($urandom_range(0, 9) == 0) a.width_code = 3'($urandom_range(3, 7));
         else a.width_code = 3'($urandom_range(0, 2));
      end else begin
         if ($urandom_range(0, 9) == 0) a.width_code = 3'($urandom_range(5, 7));
         else a.width_code = 3'($urandom_range(0, 4));
      end
      span = bytes_moved(a);
      roll = $urandom_range(0, 99);
      if (roll < 60 && known_words.size() != 0)
         base = known_words[$urandom_range(0, known_words.size() - 1)] * 4
              + $urandom_range(0, 3);
      else if (roll < 80) base = $urandom_range(0, 2047);
      else if (roll < 90) base = $urandom_range(MEM_BYTES - 8, MEM_BYTES + 4);
      else                base = $urandom_range(0, 65535);
      if (span > 1 && $urandom_range(0, 4) != 0) base = base & ~(span - 1);
      a.address    = ADDR_W'(base);
      a.store_data = $urandom;
      return a;
   endfunction

   task automatic queue_random(input int count);
      access_type a;
      int         tries;
      repeat (count) begin
         tries = 0;
         do begin
            a = random_access();
            tries++;
         end while (touches_unknown(a) && tries < 40);
         // The top address is refused by every read, whatever the limits.
         if (touches_unknown(a)) a.address = '1;
         queue_access(a);
      end
   endtask

   // -------------------------------------------------------------------------
   // Register writes and phase control
   // -------------------------------------------------------------------------
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] text_lim,
                             input logic [LIMIT_W-1:0] ro_lim);
      write_register(CSR_TEXT_LIMIT, text_lim);
      write_register(CSR_RODATA_LIMIT, ro_lim);
      plan_text   = text_lim;
      plan_rodata = ro_lim;
      settings_run++;
      @(posedge clock);
   endtask

   // Wait until every queued transaction has been driven and answered. Every
   // request yields exactly one response, so an empty prediction queue means
   // the unit is idle. The check is made at the rising edge, where the driven
   // request is settled.
   task automatic drain();
      do @(posedge clock);
      while (access_backlog.size() != 0 || req_chan.valid || awaited_replies.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: a new transaction is offered at the falling edge once the
   // previous one has been accepted, with occasional idle cycles.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      access_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (access_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
            nxt = access_backlog.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.op         <= nxt.op;
            req_chan.width_code <= nxt.width_code;
            req_chan.address    <= nxt.address;
            req_chan.store_data <= nxt.store_data;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // The response side stalls now and then, except in the calm phase.
   always @(negedge clock) begin : response_stall
      rsp_chan.ready <= !reset && (calm || $urandom_range(0, 99) >= 8);
   end

   // -------------------------------------------------------------------------
   // Monitor: at each rising edge it follows register writes, predicts the
   // reply of each accepted request and checks each accepted response against
   // the oldest prediction. The watchdog lives here too.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      access_type taken;
      reply_type  want;
      bit         moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            moved = 1'b1;
            if (csr_chan.index == CSR_TEXT_LIMIT) model_text = csr_chan.data;
            else model_rodata = csr_chan.data;
         end
         // Predict before checking, in case a reply ever comes in the same cycle.
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            taken.op         = req_chan.op;
            taken.width_code = req_chan.width_code;
            taken.address    = req_chan.address;
            taken.store_data = req_chan.store_data;
            op_count[taken.op]++;
            awaited_replies.push_back(memory_reply(taken));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            status_count[rsp_chan.status]++;
            if (awaited_replies.size() == 0) begin
               $error("response transaction with no request outstanding: data %h status %0d",
                      rsp_chan.read_data, rsp_chan.status);
               failures++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_chan.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_chan.read_data);
                  failures++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  failures++;
               end
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
      req_taken <= req_chan.valid && req_chan.ready;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", stall_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer: reset, then five phases, each under its own pair of limits.
   // -------------------------------------------------------------------------
   initial begin : sequencer
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_FETCH;
      req_chan.width_code = WC_BYTE;
      req_chan.address    = '0;
      req_chan.store_data = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_TEXT_LIMIT;
      csr_chan.data       = '0;
      req_taken           = 1'b0;
      model_text          = '0;
      model_rodata        = '0;
      plan_text           = '0;
      plan_rodata         = '0;
      calm                = 1'b0;
      failures            = 0;
      stall_cycles        = 0;
      settings_run        = 0;
      reset               = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: no protection at all. Note that address zero always lies
      // inside the code segment, so the lowest byte can never be stored and
      // is never read back. The directed part walks every load width across
      // one word, patches it with a byte and a half store, exercises the last
      // word of memory and then every kind of refusal.
      set_limits(LIMIT_MIN, LIMIT_MIN);
      queue_access(acc(OP_STORE, WC_WORD,  4, 32'hF00D_8180));
      queue_access(acc(OP_LOAD,  WC_BYTE,  4, '0));
      queue_access(acc(OP_LOAD,  WC_BYTE,  6, '0));
      queue_access(acc(OP_LOAD,  WC_UBYTE, 4, '0));
      queue_access(acc(OP_LOAD,  WC_HALF,  4, '0));
      queue_access(acc(OP_LOAD,  WC_HALF,  6, '0));
      queue_access(acc(OP_LOAD,  WC_UHALF, 6, '0));
      queue_access(acc(OP_LOAD,  WC_WORD,  4, '0));
      queue_access(acc(OP_STORE, WC_BYTE,  5, 32'hFFFF_FF7E));
      queue_access(acc(OP_STORE, WC_HALF,  6, 32'h1234_00FF));
      queue_access(acc(OP_LOAD,  WC_WORD,  4, '0));
      queue_access(acc(OP_STORE, WC_WORD,  MEM_BYTES - 4, 32'hFFFF_FFFF));
      queue_access(acc(OP_LOAD,  WC_WORD,  MEM_BYTES - 4, '0));
      queue_access(acc(OP_LOAD,  WC_UHALF, MEM_BYTES - 2, '0));
      // Refusals: off the end, misaligned, bad width codes and the unused op.
      queue_access(acc(OP_LOAD,  WC_WORD,  MEM_BYTES, '0));
      queue_access(acc(OP_LOAD,  WC_HALF,  MEM_BYTES - 1, '0));
      queue_access(acc(OP_LOAD,  WC_WORD,  6, '0));
      queue_access(acc(OP_LOAD,  WC_BYTE,  65535, '0));
      queue_access(acc(OP_LOAD,  WC_UNUSED, 4, '0));
      queue_access(acc(OP_LOAD,  WC_UNUSED_LAST, 4, '0));
      queue_access(acc(OP_UNUSED, WC_WORD, 4, 32'hDEAD_BEEF));
      // Store refusals: load-only width, protected address zero, misaligned
      // half, word past the end; and a fetch beyond an empty code segment.
      queue_access(acc(OP_STORE, WC_UBYTE, 8, 32'h5555_AAAA));
      queue_access(acc(OP_STORE, WC_WORD,  0, 32'h0BAD_0BAD));
      queue_access(acc(OP_STORE, WC_HALF,  9, 32'hAAAA_5555));
      queue_access(acc(OP_STORE, WC_WORD,  65532, 32'h1357_9BDF));
      queue_access(acc(OP_FETCH, WC_WORD,  4, '0));
      queue_random(250);
      drain();

      // Phase two: a code segment over the first kilobyte, read-only data up
      // to 2 KiB. Fetches now succeed on words filled in phase one.
      set_limits(14'd1023, 14'd2047);
      queue_access(acc(OP_FETCH, WC_WORD,  4, '0));
      queue_access(acc(OP_FETCH, WC_WORD,  6, '0));
      queue_access(acc(OP_FETCH, WC_WORD,  2048, '0));
      queue_access(acc(OP_STORE, WC_WORD,  2044, 32'hCAFE_F00D));
      queue_access(acc(OP_STORE, WC_WORD,  2048, 32'h8000_0001));
      queue_random(200);
      drain();

      // Phase three: all of memory is code, and neither side idles.
      set_limits(LIMIT_MAX, LIMIT_MIN);
      calm = 1'b1;
      queue_random(150);
      drain();
      calm = 1'b0;

      // Phase four: all of memory is read-only data.
      set_limits(LIMIT_MIN, LIMIT_MAX);
      queue_random(100);
      drain();

      // Phase five: limits drawn at random, often not on a word boundary.
      set_limits(LIMIT_W'($urandom_range(512, 3000)), LIMIT_W'($urandom_range(0, 4000)));
      queue_random(180);
      drain();

      repeat (8) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         $error("%0d responses never arrived", awaited_replies.size());
         failures++;
      end
      $display("Covered %0d fetches, %0d loads, %0d stores and %0d unused ops",
               op_count[OP_FETCH], op_count[OP_LOAD], op_count[OP_STORE],
               op_count[OP_UNUSED]);
      $display("under %0d limit settings; by status: ok %0d, unaligned %0d, %s %0d, %s %0d, %s %0d.",
               settings_run, status_count[ST_OK], status_count[ST_UNALIGNED],
               "outside text", status_count[ST_FETCH_OUTSIDE],
               "protected", status_count[ST_PROTECTED], "bad", status_count[ST_BAD]);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
